[rtl/scaled_font_glyph_pixel_generator_unit_defines.svh]
// Assertion macros shared by the checker of the glyph pixel unit.
// Every macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef SCALED_FONT_GLYPH_PIXEL_GENERATOR_UNIT_DEFINES_SVH
`define SCALED_FONT_GLYPH_PIXEL_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold after the antecedent, delayed by dly.
`define SFG_ASSERT_DLY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

[rtl/sfg_pkg.sv]
package sfg_pkg;

  // Field widths.
  localparam int unsigned CodeW    = 8;
  localparam int unsigned CoordW   = 10;
  localparam int unsigned PixW     = 11;
  localparam int unsigned OffW     = 6;
  localparam int unsigned ScaleW   = 4;
  localparam int unsigned ColorW   = 16;
  localparam int unsigned GlyphIdxW = 6;
  localparam int unsigned UnitW    = 3;
  localparam int unsigned CfgIdxW  = 2;

  // Default for the top-level scale limit.
  localparam int unsigned MaxScaleDef = 8;

  // Character set and cell geometry.
  localparam logic [CodeW-1:0] GlyphFirst  = 8'h20;
  localparam logic [CodeW-1:0] GlyphLast   = 8'h5F;
  localparam logic [CodeW-1:0] LowerFirst  = 8'h61;
  localparam logic [CodeW-1:0] LowerLast   = 8'h7A;
  localparam logic [CodeW-1:0] CaseOffset  = 8'h20;
  localparam logic [CodeW-1:0] SubstCode   = 8'h3F;
  localparam int unsigned      GlyphCols   = 5;
  localparam int unsigned      CellCols    = 6;
  localparam int unsigned      CellRows    = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 2'd1;

  // Register reset values.
  localparam logic [CoordW-1:0] ScreenWidthRst  = 10'd390;
  localparam logic [CoordW-1:0] ScreenHeightRst = 10'd450;

  // Word after the first stage: folded code, raw offsets and the cell/screen test.
  typedef struct packed {
    logic [GlyphIdxW-1:0] glyph_idx;
    logic [PixW-1:0]      px;
    logic [PixW-1:0]      py;
    logic [ScaleW-1:0]    scale;
    logic [OffW-1:0]      dx;
    logic [OffW-1:0]      dy;
    logic [ColorW-1:0]    fg;
    logic [ColorW-1:0]    bg;
    logic                 in_cell;
  } prep_t;

  // Word after the second stage: glyph unit coordinates.
  typedef struct packed {
    logic [GlyphIdxW-1:0] glyph_idx;
    logic [PixW-1:0]      px;
    logic [PixW-1:0]      py;
    logic [UnitW-1:0]     ux;
    logic [UnitW-1:0]     uy;
    logic [ColorW-1:0]    fg;
    logic [ColorW-1:0]    bg;
    logic                 in_cell;
  } unit_t;

  // Font: five column bytes per glyph, leftmost column in the top byte, bit 0 the top row.
  localparam logic [39:0] GlyphRom [64] = '{
    40'h00_00_00_00_00, 40'h00_00_5f_00_00, 40'h00_07_00_07_00, 40'h14_7f_14_7f_14,
    40'h24_2a_7f_2a_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
    40'h00_1c_22_41_00, 40'h00_41_22_1c_00, 40'h14_08_3e_08_14, 40'h08_08_3e_08_08,
    40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
    40'h3e_51_49_45_3e, 40'h00_42_7f_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4b_31,
    40'h18_14_12_7f_10, 40'h27_45_45_45_39, 40'h3c_4a_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1e, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
    40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
    40'h32_49_79_41_3e, 40'h7e_11_11_11_7e, 40'h7f_49_49_49_36, 40'h3e_41_41_41_22,
    40'h7f_41_41_22_1c, 40'h7f_49_49_49_41, 40'h7f_09_09_09_01, 40'h3e_41_49_49_7a,
    40'h7f_08_08_08_7f, 40'h00_41_7f_41_00, 40'h20_40_41_3f_01, 40'h7f_08_14_22_41,
    40'h7f_40_40_40_40, 40'h7f_02_0c_02_7f, 40'h7f_04_08_10_7f, 40'h3e_41_41_41_3e,
    40'h7f_09_09_09_06, 40'h3e_41_51_21_5e, 40'h7f_09_19_29_46, 40'h46_49_49_49_31,
    40'h01_01_7f_01_01, 40'h3f_40_40_40_3f, 40'h1f_20_40_20_1f, 40'h3f_40_38_40_3f,
    40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7f_41_41_00,
    40'h02_04_08_10_20, 40'h00_41_41_7f_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40
  };

  // One font bit. The spacing column reads as zero; every column byte has its top bit clear,
  // so the spacing row reads as zero too.
  function automatic logic glyph_bit(input logic [GlyphIdxW-1:0] idx,
                                     input logic [UnitW-1:0] ux,
                                     input logic [UnitW-1:0] uy);
    logic [39:0] row;
    logic [7:0]  col;
    row = GlyphRom[idx];
    case (ux)
      3'd0: col = row[39:32];
      3'd1: col = row[31:24];
      3'd2: col = row[23:16];
      3'd3: col = row[15:8];
      3'd4: col = row[7:0];
      default: col = '0;
    endcase
    return col[uy];
  endfunction

endpackage

[rtl/scaled_font_glyph_pixel_generator_unit.sv]
// Scaled 5x7 font pixel unit.
// Input: one word per cycle on start with the pixel fields (character code, cell
// origin, offset inside the cell, scale, foreground and background colors). busy
// is always low, so every cycle with start high takes a word.
// Output: each word gives exactly one result, marked by a one-cycle valid_o
// strobe: screen coordinate, RGB565 color and the visible flag.
// The receiver cannot stall; results leave in order at the rate they came in.
// Throughput is one word per clock. Each word passes the register stages in order:
// code folding with cell and screen tests, the scale divider (three restoring
// steps), then the font lookup and color select.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i write the
// screen width (index 0) and height (index 1); cfg_ready_o is always high and
// writes to other indexes are ignored. Write only while no word is in flight.
// Reset clears the pipeline valid bits and restores the screen size to 390 by 450.
module scaled_font_glyph_pixel_generator_unit #(
  parameter int unsigned MAX_SCALE = sfg_pkg::MaxScaleDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [sfg_pkg::CodeW-1:0]    char_code_i,
  input  logic [sfg_pkg::CoordW-1:0]   origin_x_i,
  input  logic [sfg_pkg::CoordW-1:0]   origin_y_i,
  input  logic [sfg_pkg::OffW-1:0]     offset_x_i,
  input  logic [sfg_pkg::OffW-1:0]     offset_y_i,
  input  logic [sfg_pkg::ScaleW-1:0]   scale_i,
  input  logic [sfg_pkg::ColorW-1:0]   fg_color_i,
  input  logic [sfg_pkg::ColorW-1:0]   bg_color_i,
  output logic                         valid_o,
  output logic [sfg_pkg::PixW-1:0]     pixel_x_o,
  output logic [sfg_pkg::PixW-1:0]     pixel_y_o,
  output logic [sfg_pkg::ColorW-1:0]   pixel_color_o,
  output logic                         visible_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sfg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sfg_pkg::CoordW-1:0]   cfg_data_i
);
  import sfg_pkg::*;

  logic [CoordW-1:0] screen_width_q;
  logic [CoordW-1:0] screen_width_d;
  logic [CoordW-1:0] screen_height_q;
  logic [CoordW-1:0] screen_height_d;
  logic              in_take;
  logic              prep_valid;
  prep_t             prep_word;
  logic              unit_valid;
  unit_t             unit_word;

  // The pipeline never stalls.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_take     = start && !busy;

  // Configuration register writes.
  always_comb begin
    screen_width_d  = screen_width_q;
    screen_height_d = screen_height_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgScreenWidth:  screen_width_d  = cfg_data_i;
        CfgScreenHeight: screen_height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= ScreenWidthRst;
      screen_height_q <= ScreenHeightRst;
    end else begin
      screen_width_q  <= screen_width_d;
      screen_height_q <= screen_height_d;
    end
  end

  sfg_prep #(
    .MAX_SCALE(MAX_SCALE)
  ) u_prep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_take),
    .char_code_i    (char_code_i),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .offset_x_i     (offset_x_i),
    .offset_y_i     (offset_y_i),
    .scale_i        (scale_i),
    .fg_color_i     (fg_color_i),
    .bg_color_i     (bg_color_i),
    .screen_width_i (screen_width_q),
    .screen_height_i(screen_height_q),
    .valid_o        (prep_valid),
    .word_o         (prep_word)
  );

  sfg_divide u_divide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(prep_valid),
    .word_i (prep_word),
    .valid_o(unit_valid),
    .word_o (unit_word)
  );

  sfg_glyph u_glyph (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (unit_valid),
    .word_i       (unit_word),
    .valid_o      (valid_o),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_color_o(pixel_color_o),
    .visible_o    (visible_o)
  );

endmodule

[rtl/sfg_prep.sv]
module sfg_prep #(
  parameter int unsigned MAX_SCALE = sfg_pkg::MaxScaleDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [sfg_pkg::CodeW-1:0]    char_code_i,
  input  logic [sfg_pkg::CoordW-1:0]   origin_x_i,
  input  logic [sfg_pkg::CoordW-1:0]   origin_y_i,
  input  logic [sfg_pkg::OffW-1:0]     offset_x_i,
  input  logic [sfg_pkg::OffW-1:0]     offset_y_i,
  input  logic [sfg_pkg::ScaleW-1:0]   scale_i,
  input  logic [sfg_pkg::ColorW-1:0]   fg_color_i,
  input  logic [sfg_pkg::ColorW-1:0]   bg_color_i,
  input  logic [sfg_pkg::CoordW-1:0]   screen_width_i,
  input  logic [sfg_pkg::CoordW-1:0]   screen_height_i,
  output logic                         valid_o,
  output sfg_pkg::prep_t               word_o
);
  import sfg_pkg::*;

  localparam logic [ScaleW-1:0] MaxScaleL = ScaleW'(MAX_SCALE);
  localparam int unsigned       CellW     = OffW + 1;

  logic [CodeW-1:0]  code_fold;
  logic [CodeW-1:0]  code_sel;
  logic [ScaleW-1:0] scale_sat;
  logic [CellW-1:0]  cell_w;
  logic [CellW-1:0]  cell_h;
  logic [PixW-1:0]   px;
  logic [PixW-1:0]   py;
  logic              valid_q;
  prep_t             word_d;
  prep_t             word_q;

  // Fold lower case to upper case and replace codes without a glyph.
  always_comb begin
    code_fold = char_code_i;
    if (char_code_i >= LowerFirst && char_code_i <= LowerLast) begin
      code_fold = char_code_i - CaseOffset;
    end
    code_sel = code_fold;
    if (code_fold < GlyphFirst || code_fold > GlyphLast) begin
      code_sel = SubstCode;
    end
  end

  // Clamp the scale and find the cell size in pixels.
  always_comb begin
    scale_sat = (scale_i > MaxScaleL) ? MaxScaleL : scale_i;
    cell_w    = CellW'(scale_sat) * CellW'(CellCols);
    cell_h    = CellW'(scale_sat) * CellW'(CellRows);
    px        = PixW'(origin_x_i) + PixW'(offset_x_i);
    py        = PixW'(origin_y_i) + PixW'(offset_y_i);
  end

  // Build the word for the divider stage.
  always_comb begin
    word_d.glyph_idx = GlyphIdxW'(code_sel - GlyphFirst);
    word_d.px        = px;
    word_d.py        = py;
    word_d.scale     = scale_sat;
    word_d.dx        = offset_x_i;
    word_d.dy        = offset_y_i;
    word_d.fg        = fg_color_i;
    word_d.bg        = bg_color_i;
    word_d.in_cell   = (scale_sat != '0) &&
                       (CellW'(offset_x_i) < cell_w) && (CellW'(offset_y_i) < cell_h) &&
                       (px < PixW'(screen_width_i)) && (py < PixW'(screen_height_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

[rtl/sfg_divide.sv]
module sfg_divide (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  sfg_pkg::prep_t word_i,
  output logic           valid_o,
  output sfg_pkg::unit_t word_o
);
  import sfg_pkg::*;

  localparam int unsigned RemW = OffW + 1;

  logic  valid_q;
  unit_t word_d;
  unit_t word_q;

  // Restoring division of a cell offset by the scale. Inside the cell the
  // quotient is below eight, so three steps are enough; outside it is unused.
  function automatic logic [UnitW-1:0] unit_div(input logic [OffW-1:0] off,
                                                input logic [ScaleW-1:0] scl);
    logic [RemW-1:0]  rem;
    logic [RemW-1:0]  dvs;
    logic [UnitW-1:0] q;
    rem = RemW'(off);
    q   = '0;
    for (int k = UnitW - 1; k >= 0; k--) begin
      dvs = RemW'(scl) << k;
      if (rem >= dvs) begin
        rem  = rem - dvs;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  always_comb begin
    word_d.glyph_idx = word_i.glyph_idx;
    word_d.px        = word_i.px;
    word_d.py        = word_i.py;
    word_d.ux        = unit_div(word_i.dx, word_i.scale);
    word_d.uy        = unit_div(word_i.dy, word_i.scale);
    word_d.fg        = word_i.fg;
    word_d.bg        = word_i.bg;
    word_d.in_cell   = word_i.in_cell;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

[rtl/sfg_glyph.sv]
module sfg_glyph (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  sfg_pkg::unit_t              word_i,
  output logic                        valid_o,
  output logic [sfg_pkg::PixW-1:0]    pixel_x_o,
  output logic [sfg_pkg::PixW-1:0]    pixel_y_o,
  output logic [sfg_pkg::ColorW-1:0]  pixel_color_o,
  output logic                        visible_o
);
  import sfg_pkg::*;

  logic              lit;
  logic [ColorW-1:0] color_d;
  logic              valid_q;
  logic [PixW-1:0]   pixel_x_q;
  logic [PixW-1:0]   pixel_y_q;
  logic [ColorW-1:0] color_q;
  logic              visible_q;

  // Font lookup and color select; a hidden pixel reports color zero.
  always_comb begin
    lit     = glyph_bit(word_i.glyph_idx, word_i.ux, word_i.uy);
    color_d = '0;
    if (word_i.in_cell) begin
      color_d = lit ? word_i.fg : word_i.bg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      pixel_x_q <= word_i.px;
      pixel_y_q <= word_i.py;
      color_q   <= color_d;
      visible_q <= word_i.in_cell;
    end
  end

  assign valid_o       = valid_q;
  assign pixel_x_o     = pixel_x_q;
  assign pixel_y_o     = pixel_y_q;
  assign pixel_color_o = color_q;
  assign visible_o     = visible_q;

endmodule

[rtl/sfg_checker.sv]
`include "scaled_font_glyph_pixel_generator_unit_defines.svh"

module sfg_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic [sfg_pkg::CoordW-1:0]   origin_x_i,
  input logic [sfg_pkg::CoordW-1:0]   origin_y_i,
  input logic [sfg_pkg::OffW-1:0]     offset_x_i,
  input logic [sfg_pkg::OffW-1:0]     offset_y_i,
  input logic [sfg_pkg::ScaleW-1:0]   scale_i,
  input logic                         valid_o,
  input logic [sfg_pkg::PixW-1:0]     pixel_x_o,
  input logic [sfg_pkg::PixW-1:0]     pixel_y_o,
  input logic [sfg_pkg::ColorW-1:0]   pixel_color_o,
  input logic                         visible_o
);
  import sfg_pkg::*;

  localparam int unsigned OutLatency = 3;

  // Every accepted word leaves after the pipeline latency.
  `SFG_ASSERT_DLY(a_word_out, start && !busy, OutLatency, valid_o, "accepted word produced no result")

  // No result without a word accepted at the right time.
  `SFG_ASSERT_IMP(a_no_extra, valid_o, $past(start && !busy, OutLatency), "result without a word")

  // The screen coordinate is the cell origin plus the offset.
  `SFG_ASSERT_IMP(a_coord, valid_o, (pixel_x_o == PixW'($past(origin_x_i, OutLatency)) + PixW'($past(offset_x_i, OutLatency))) && (pixel_y_o == PixW'($past(origin_y_i, OutLatency)) + PixW'($past(offset_y_i, OutLatency))), "pixel coordinate mismatch")

  // A hidden pixel reports color zero.
  `SFG_ASSERT_IMP(a_hidden_color, valid_o && !visible_o, pixel_color_o == '0, "hidden pixel has a color")

  // A zero scale never gives a visible pixel.
  `SFG_ASSERT_IMP(a_zero_scale, valid_o && visible_o, $past(scale_i, OutLatency) != '0, "visible pixel from zero scale")

endmodule

bind scaled_font_glyph_pixel_generator_unit sfg_checker u_sfg_checker (.*);
